/* rtl/core/psw_pkg.sv */
// Shared types and constants for the per-sensor window average block.
package psw_pkg;

    localparam int NUM_SENSORS_DEF = 16;
    localparam int WINDOW_LEN_DEF  = 6;

    localparam int SAMPLE_W = 16;
    localparam int SENSOR_W = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_LEVEL_THRESHOLD = '0;
    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET     = 16'd3840;

    localparam logic KIND_AVG    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SUM,
        ST_DIV,
        ST_AVG,
        ST_RD,
        ST_OUT
    } psw_state_t;

    typedef struct packed {
        logic s_ready;
        logic mem_we;
        logic sum_run;
        logic div_start;
        logic load_avg;
        logic load_win;
    } psw_ctrl_t;

endpackage

/* rtl/core/psw_div.sv */
// Bit-serial restoring divider that produces one quotient bit per cycle.
module psw_div #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;

    // The remainder stays below the divisor, so the trial value is below twice it.
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = (trial >= {1'b0, divisor});
    assign diff     = trial - {1'b0, divisor};
    assign rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/per_sensor_window_average_threshold_top.sv */
// Top level of the per-sensor sliding window average with threshold report.
//
// Usage: an input item carries a sensor number and an unsigned Q8.8 sample.
// The sample enters that sensor's window of the last WINDOW_LEN samples, and
// the truncated average of the filled entries is formed. An average below
// level_threshold gives one result item (kind 0, last set); otherwise one
// result item per filled entry carries the window samples oldest first, with
// last set on the final one. A sensor number at or above NUM_SENSORS is
// dropped and gives no result.
// Timing: one item is in work at a time and s_ready is low meanwhile. The
// window is summed through one memory read port, one entry a cycle, and the
// average comes from a bit-serial divider yielding one quotient bit per
// cycle, for each sum bit (19 at the default sizes). After the division an
// average report is loaded directly, while each window sample is first read
// from memory and then loaded into the output register.
// The last result waits in the output register while the next item is taken.
// Reset clears all fill counts and restores level_threshold to 15.0; the
// window memory itself is not cleared, since only filled entries are read.
// A stalled receiver simply holds the sequencer before each result item.
module per_sensor_window_average_threshold_top #(
    parameter int NUM_SENSORS = psw_pkg::NUM_SENSORS_DEF,
    parameter int WINDOW_LEN  = psw_pkg::WINDOW_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [psw_pkg::SENSOR_W-1:0]    s_sensor_id,
    input  logic [psw_pkg::SAMPLE_W-1:0]    s_sample,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [psw_pkg::SENSOR_W-1:0]    m_report_sensor,
    output logic                            m_report_kind,
    output logic [psw_pkg::SAMPLE_W-1:0]    m_value,
    output logic                            m_last,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int SAMPLE_W = psw_pkg::SAMPLE_W;
    localparam int SENSOR_W = psw_pkg::SENSOR_W;
    localparam int SID_W    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SLOT_W   = $clog2(WINDOW_LEN);
    localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int DEPTH    = NUM_SENSORS * WINDOW_LEN;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] thr_reg;
    logic                cfg_sel;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[psw_pkg::APB_ADDR_W-1:2] == psw_pkg::REG_LEVEL_THRESHOLD);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? psw_pkg::APB_DATA_W'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= psw_pkg::THRESHOLD_RESET;
        end else if (cfg_wr) begin
            thr_reg <= pwdata[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Per-sensor bookkeeping. Each window is a ring in the memory: while it
    // fills, the oldest entry is slot zero; once full, head points at it.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  fill_reg [NUM_SENSORS];
    logic [SLOT_W-1:0] head_reg [NUM_SENSORS];

    psw_pkg::psw_state_t state_reg, state_next;
    psw_pkg::psw_ctrl_t  ctrl;

    logic [SID_W-1:0]    in_sid;
    logic                id_ok;
    logic                take;
    logic [CNT_W-1:0]    old_cnt;
    logic [SLOT_W-1:0]   old_head;
    logic                not_full;
    logic [SLOT_W-1:0]   head_inc;
    logic [CNT_W-1:0]    new_cnt;
    logic [SLOT_W-1:0]   new_head;
    logic [SLOT_W-1:0]   in_wr_slot;
    logic [ADDR_W-1:0]   in_base;

    assign in_sid     = SID_W'(s_sensor_id);
    assign id_ok      = (32'(s_sensor_id) < NUM_SENSORS);
    assign take       = s_valid && ctrl.s_ready && id_ok;
    assign old_cnt    = fill_reg[in_sid];
    assign old_head   = head_reg[in_sid];
    assign not_full   = (old_cnt < CNT_W'(WINDOW_LEN));
    assign head_inc   = (old_head == SLOT_W'(WINDOW_LEN - 1)) ? '0 : old_head + 1'b1;
    assign new_cnt    = not_full ? old_cnt + 1'b1 : old_cnt;
    assign new_head   = not_full ? '0 : head_inc;
    assign in_wr_slot = not_full ? SLOT_W'(old_cnt) : old_head;
    assign in_base    = ADDR_W'(in_sid) * ADDR_W'(WINDOW_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end else if (take) begin
            fill_reg[in_sid] <= new_cnt;
            head_reg[in_sid] <= new_head;
        end
    end

    // ------------------------------------------------------------------
    // Item registers and the window memory.
    // ------------------------------------------------------------------
    logic [SENSOR_W-1:0] sensor_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [SLOT_W-1:0]   wr_slot_reg;
    logic [SLOT_W-1:0]   oldest_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                rd_pend_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] rdata_reg;

    logic [SAMPLE_W-1:0] window_mem [DEPTH];

    logic [SLOT_W:0]     rd_sum;
    logic [SLOT_W-1:0]   rd_slot;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                issue;
    logic                out_free;
    logic                win_last;

    // Ring position of the idx-th oldest entry; a single wrap is enough.
    assign rd_sum  = {1'b0, oldest_reg} + (SLOT_W + 1)'(idx_reg);
    assign rd_slot = (rd_sum >= (SLOT_W + 1)'(WINDOW_LEN)) ?
                     SLOT_W'(rd_sum - (SLOT_W + 1)'(WINDOW_LEN)) : SLOT_W'(rd_sum);
    assign rd_addr = base_reg + ADDR_W'(rd_slot);
    assign wr_addr = base_reg + ADDR_W'(wr_slot_reg);

    assign issue    = (idx_reg < cnt_reg);
    assign out_free = !m_valid || m_ready;
    assign win_last = ((idx_reg + 1'b1) == cnt_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.mem_we) begin
            window_mem[wr_addr] <= sample_reg;
        end
        rdata_reg <= window_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            sensor_reg  <= s_sensor_id;
            sample_reg  <= s_sample;
            base_reg    <= in_base;
            wr_slot_reg <= in_wr_slot;
            oldest_reg  <= new_head;
            cnt_reg     <= new_cnt;
        end
    end

    // Accumulator: one read issued and one earlier read added each cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            if (take || ctrl.div_start) begin
                idx_reg <= '0;
            end else if ((ctrl.sum_run && issue) || ctrl.load_win) begin
                idx_reg <= idx_reg + 1'b1;
            end
            rd_pend_reg <= ctrl.sum_run && issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            sum_reg <= '0;
        end else if (ctrl.sum_run && rd_pend_reg) begin
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
        end
    end

    // ------------------------------------------------------------------
    // Shared divider for the average.
    // ------------------------------------------------------------------
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic             below;

    psw_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign below = (div_quo < SUM_W'(thr_reg));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psw_pkg::ST_IDLE: begin
                if (take) begin
                    state_next = psw_pkg::ST_WRITE;
                end
            end
            psw_pkg::ST_WRITE: begin
                state_next = psw_pkg::ST_SUM;
            end
            psw_pkg::ST_SUM: begin
                if (!issue && !rd_pend_reg) begin
                    state_next = psw_pkg::ST_DIV;
                end
            end
            psw_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = below ? psw_pkg::ST_AVG : psw_pkg::ST_RD;
                end
            end
            psw_pkg::ST_AVG: begin
                if (out_free) begin
                    state_next = psw_pkg::ST_IDLE;
                end
            end
            psw_pkg::ST_RD: begin
                state_next = psw_pkg::ST_OUT;
            end
            psw_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = win_last ? psw_pkg::ST_IDLE : psw_pkg::ST_RD;
                end
            end
            default: begin
                state_next = psw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            psw_pkg::ST_IDLE: begin
                ctrl.s_ready = 1'b1;
            end
            psw_pkg::ST_WRITE: begin
                ctrl.mem_we = 1'b1;
            end
            psw_pkg::ST_SUM: begin
                ctrl.sum_run   = 1'b1;
                ctrl.div_start = !issue && !rd_pend_reg;
            end
            psw_pkg::ST_AVG: begin
                ctrl.load_avg = out_free;
            end
            psw_pkg::ST_OUT: begin
                ctrl.load_win = out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    assign s_ready = ctrl.s_ready;

    // ------------------------------------------------------------------
    // Output register: it holds a result until it is taken, so the
    // sequencer may already be back in idle with a new item.
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    logic [SENSOR_W-1:0] m_sensor_reg;
    logic                m_kind_reg;
    logic [SAMPLE_W-1:0] m_value_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_avg || ctrl.load_win) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_avg) begin
            m_sensor_reg <= sensor_reg;
            m_kind_reg   <= psw_pkg::KIND_AVG;
            m_value_reg  <= SAMPLE_W'(div_quo);
            m_last_reg   <= 1'b1;
        end else if (ctrl.load_win) begin
            m_sensor_reg <= sensor_reg;
            m_kind_reg   <= psw_pkg::KIND_SAMPLE;
            m_value_reg  <= rdata_reg;
            m_last_reg   <= win_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_report_sensor = m_sensor_reg;
    assign m_report_kind   = m_kind_reg;
    assign m_value         = m_value_reg;
    assign m_last          = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_avg_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_report_kind == psw_pkg::KIND_AVG) |-> m_last)
        else $error("average result without last");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psw_pkg::ST_SUM) |->
            (cnt_reg != '0) && (cnt_reg <= CNT_W'(WINDOW_LEN)))
        else $error("fill count out of range while summing");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == psw_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    a_win_index: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_win |-> (idx_reg < cnt_reg))
        else $error("window result beyond filled entries");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_last))
        else $error("pending result overwritten");

endmodule

/* tb/sv/tb_per_sensor_window_average_threshold_top.sv */
// Self-checking testbench for the per-sensor window average block with its threshold report.
module tb_per_sensor_window_average_threshold_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = psw_pkg::SAMPLE_W;
    localparam int SENSOR_W      = psw_pkg::SENSOR_W;
    localparam int APB_ADDR_W    = psw_pkg::APB_ADDR_W;
    localparam int APB_DATA_W    = psw_pkg::APB_DATA_W;

    // The block is built with its default sizes, so the predictor uses the same ones.
    localparam int SENSORS       = psw_pkg::NUM_SENSORS_DEF;
    localparam int WIN_LEN       = psw_pkg::WINDOW_LEN_DEF;

    // Random stalls on both sides and the long hold-off lengthen the run. The limit
    // below is many times the worst case for roughly 110 items.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 20;

    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR =
        APB_ADDR_W'(psw_pkg::REG_LEVEL_THRESHOLD) << 2;

    // One expected result item, with fields in the block's widths.
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic                kind;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } window_report_t;

    // Every input of the block starts at a known value.
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SENSOR_W-1:0]   s_sensor_id = '0;
    logic [SAMPLE_W-1:0]   s_sample    = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SENSOR_W-1:0]   m_report_sensor;
    logic                  m_report_kind;
    logic [SAMPLE_W-1:0]   m_value;
    logic                  m_last;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // The predictor keeps its own copy of every sensor window, fill count and threshold.
    window_report_t        pending_reports[$];
    logic [SAMPLE_W-1:0]   window_copy [SENSORS][WIN_LEN];
    int unsigned           fill_copy [SENSORS];
    logic [SAMPLE_W-1:0]   threshold_copy = psw_pkg::THRESHOLD_RESET;

    int                    failures    = 0;
    int unsigned           cycle_count = 0;
    int                    tx_idle_pct = 33;
    int                    rx_idle_pct = 33;
    logic                  hold_go     = 1'b0;
    int                    hold_left   = 0;

    per_sensor_window_average_threshold_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_id     (s_sensor_id),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_report_sensor (m_report_sensor),
        .m_report_kind   (m_report_kind),
        .m_value         (m_value),
        .m_last          (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // The watchdog ends a run that hangs, for instance on a lost result item.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // Counts the failures and shows only the first few of them in detail.
    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endfunction

    // Applies one accepted sample to the predicted sensor window and queues the
    // result items that it causes: the truncated average when it lies below the
    // threshold, else every filled entry oldest first with the final one marked.
    function automatic void predict_window_report(input logic [SENSOR_W-1:0] id,
                                                  input logic [SAMPLE_W-1:0] smp);
        int unsigned n;
        logic [31:0] total;
        logic [31:0] mean;
        if (id >= SENSORS) begin
            return;
        end
        n = fill_copy[id];
        if (n < WIN_LEN) begin
            window_copy[id][n] = smp;
            n++;
        end else begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                window_copy[id][i] = window_copy[id][i + 1];
            end
            window_copy[id][WIN_LEN - 1] = smp;
        end
        fill_copy[id] = n;
        total = '0;
        for (int i = 0; i < int'(n); i++) begin
            total += window_copy[id][i];
        end
        mean = total / n;
        if (mean < threshold_copy) begin
            pending_reports.push_back('{sensor: id, kind: psw_pkg::KIND_AVG,
                                        value: mean[SAMPLE_W-1:0], last: 1'b1});
        end else begin
            for (int i = 0; i < int'(n); i++) begin
                pending_reports.push_back('{sensor: id, kind: psw_pkg::KIND_SAMPLE,
                                            value: window_copy[id][i],
                                            last: (i == int'(n) - 1)});
            end
        end
    endfunction

    // Compares one accepted result item with the oldest expectation.
    function automatic void check_report();
        window_report_t want;
        if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected item sensor %0d kind %0d value %h last %0d",
                                   m_report_sensor, m_report_kind, m_value, m_last));
            return;
        end
        want = pending_reports.pop_front();
        if (m_report_sensor !== want.sensor || m_report_kind !== want.kind ||
            m_value !== want.value || m_last !== want.last) begin
            note_failure($sformatf({"expected sensor %0d kind %0d value %h last %0d, ",
                                    "got sensor %0d kind %0d value %h last %0d"},
                                   want.sensor, want.kind, want.value, want.last,
                                   m_report_sensor, m_report_kind, m_value, m_last));
        end
    endfunction

    // Receiver: outputs are sampled at the rising edge, before the block updates
    // them, and ready is redrawn every cycle. During a hold-off it stays low.
    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            check_report();
        end
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // The long hold-off counts its own cycles once a test asks for it.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    task automatic apply_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        threshold_copy = psw_pkg::THRESHOLD_RESET;
        foreach (fill_copy[i]) begin
            fill_copy[i] = 0;
        end
        @(posedge aclk);
    endtask

    // Offers one item, after a random number of idle cycles, and holds it until the
    // block takes it. Valid is only lowered in a cycle where no new item is raised.
    task automatic send_sample(input logic [SENSOR_W-1:0] id, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sensor_id <= id;
        s_sample    <= smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_window_report(id, smp);
    endtask

    // Waits until every expected result item has come back, then lets the block settle.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the threshold through the configuration port and reads it back. The read
    // follows the write directly, with psel kept high for a new setup cycle.
    task automatic write_threshold(input logic [SAMPLE_W-1:0] lvl);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= APB_DATA_W'(lvl);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        threshold_copy = lvl;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[SAMPLE_W-1:0] !== lvl) begin
            note_failure($sformatf("threshold read back expected %h, got %h",
                                   lvl, prdata[SAMPLE_W-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Draws a sample: often close to the current threshold so that both outcomes
    // occur, sometimes anywhere in the range, sometimes at an extreme.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535));
            1: v = $urandom_range(1) ? 65535 : 0;
            default: begin
                v = int'(threshold_copy) + int'($urandom_range(1024)) - 512;
            end
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return SAMPLE_W'(v);
    endfunction

    // With the reset threshold of 15.0 the averages stay below it, and a single
    // sample equal to the threshold already reports its window.
    task automatic test_average_below_threshold();
        send_sample(4'd0, 16'h0000);
        send_sample(4'd0, 16'h0100);
        send_sample(4'd0, 16'h0EFF);
        send_sample(4'd1, 16'h0EFF);
        send_sample(4'd2, 16'h0F00);
    endtask

    // A full-scale sensor reports one to six window entries, then slides its window.
    task automatic test_window_fill_and_slide();
        repeat (WIN_LEN + 1) begin
            send_sample(4'd15, 16'hFFFF);
        end
        send_sample(4'd10, 16'h1234);
    endtask

    // A threshold of zero always reports the window; the maximum threshold only
    // reports it for a window that is entirely at full scale.
    task automatic test_threshold_extremes();
        drain_reports();
        write_threshold(16'h0000);
        send_sample(4'd3, 16'h0000);
        drain_reports();
        write_threshold(16'hFFFF);
        send_sample(4'd15, 16'hFFFF);
        send_sample(4'd4, 16'hFFFE);
        send_sample(4'd5, 16'h8000);
    endtask

    // Random traffic in phases with their own thresholds. Most items go to a few
    // sensors so that their windows fill and slide; the rest go anywhere.
    // One phase runs with no idling on either side.
    task automatic test_random_traffic();
        logic [SENSOR_W-1:0] base;
        logic [SENSOR_W-1:0] id;
        for (int p = 0; p < PHASES; p++) begin
            drain_reports();
            case (p)
                0: write_threshold(SAMPLE_W'($urandom_range(65535)));
                1: write_threshold(SAMPLE_W'($urandom_range(16'h2000)));
                2: write_threshold(psw_pkg::THRESHOLD_RESET);
                default: write_threshold(SAMPLE_W'($urandom_range(65535)));
            endcase
            tx_idle_pct = (p == 2) ? 0 : 33;
            rx_idle_pct = (p == 2) ? 0 : 33;
            base = SENSOR_W'($urandom_range(15));
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(3) != 0) begin
                    id = base + SENSOR_W'($urandom_range(3));
                end else begin
                    id = SENSOR_W'($urandom_range(15));
                end
                send_sample(id, pick_sample());
            end
        end
        tx_idle_pct = 33;
        rx_idle_pct = 33;
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // output register fills and the block stops taking input.
    task automatic test_output_backpressure();
        drain_reports();
        write_threshold(16'h0800);
        tx_idle_pct = 0;
        hold_go <= 1'b1;
        while (hold_left == 0) @(posedge aclk);
        hold_go <= 1'b0;
        repeat (12) begin
            send_sample(SENSOR_W'($urandom_range(7, 6)), pick_sample());
        end
        tx_idle_pct = 33;
    endtask

    initial begin
        apply_reset();
        test_average_below_threshold();
        test_window_fill_and_slide();
        test_threshold_extremes();
        test_random_traffic();
        test_output_backpressure();
        drain_reports();
        if (failures == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
